[sv/pid_pkg.sv]
// shared constants, codes and types of the pid controller
package pid_pkg;

    // nanoseconds in one second and the bits it needs
    localparam int          NS_BITS    = 30;
    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

    // operation codes
    localparam logic [1:0] OP_DERIVE   = 2'd0;
    localparam logic [1:0] OP_SUPPLIED = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    // configuration register indexes
    localparam int                   CFG_IDX_W      = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_LIMIT  = 3'd3;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } pid_unit_st_t;

endpackage

[sv/pid_if.sv]
// handshake channels of the pid controller: sample, result and configuration

interface pid_in_if #(
    parameter int DATA_WIDTH = 32,
    parameter int DT_WIDTH   = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic signed [DATA_WIDTH-1:0] err_sample;
    logic signed [DATA_WIDTH-1:0] err_rate;
    logic [DT_WIDTH-1:0]          elapsed_ns;

    modport source (output valid, operation, err_sample, err_rate, elapsed_ns, input ready);
    modport sink   (input valid, operation, err_sample, err_rate, elapsed_ns, output ready);
endinterface

interface pid_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] command;
    logic                         cmd_valid;

    modport source (output valid, command, cmd_valid, input ready);
    modport sink   (input valid, command, cmd_valid, output ready);
endinterface

interface pid_cfg_if
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/pid_mul.sv]
// serial shift-add multiplier, one multiplier bit per cycle, msb first
module pid_mul
    import pid_pkg::*;
#(
    parameter int A_W = 49,
    parameter int B_W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output pid_unit_st_t         status,
    output logic [A_W+B_W-1:0]   product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   acc_next;
    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    // one partial product per cycle
    always_comb
    begin
        acc_next = (acc_reg << 1) + (b_reg[B_W-1] ? {{B_W{1'b0}}, a_reg} : {P_W{1'b0}});
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
        end
    end

    // bit counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(B_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

[sv/pid_div.sv]
// serial restoring divider, one quotient bit per cycle
module pid_div
    import pid_pkg::*;
#(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output pid_unit_st_t   status,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [D_W-1:0]   d_reg;
    logic [D_W:0]     rem_sh;
    logic [D_W:0]     rem_diff;
    logic             ge;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    // trial subtraction of the divisor
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[N_W-1]};
        rem_diff = rem_sh - {1'b0, d_reg};
        ge       = (rem_sh >= {1'b0, d_reg});
        rem_next = ge ? rem_diff[D_W-1:0] : rem_sh[D_W-1:0];
    end

    // dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            d_reg   <= den;
        end
        else if (cnt_reg != '0)
        begin
            q_reg   <= {q_reg[N_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    // bit counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(N_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = q_reg;

endmodule

[sv/pid_controller.sv]
// pid controller top level: sequencer, state, configuration and result register
//
// sample channel: operation, err_sample, err_rate and elapsed_ns, one transfer per
// control step; result channel: command and cmd_valid, exactly one transfer per
// sample; cfg channel: register index and data, always ready; the user must write
// it only while idle, which the block itself does not enforce. each step runs on
// one serial multiplier (one bit per cycle) and one serial divider, used in turn,
// so the block holds one sample at a time. a derive step takes five products and
// two quotients; a supplied-rate step four products and one quotient; clear, zero
// elapsed time and the unused code go straight to the final step.
// sample ready is high only while the sequencer is idle. the finished result waits
// in an output register, so the next sample is taken while the receiver stalls;
// that sample's result waits in the final step until the register is free.
// reset clears last error and integral, zeroes the gains and sets the limit to
// all ones; no result is pending after reset.
module pid_controller
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int INTEG_WIDTH = 48,
    parameter int DT_WIDTH    = 32
) (
    input logic       clk,
    input logic       rst_n,
    pid_in_if.sink    sample,
    pid_out_if.source result,
    pid_cfg_if.sink   cfg
);

    localparam int DW  = DATA_WIDTH;
    localparam int MA0 = (INTEG_WIDTH > DW + 1) ? INTEG_WIDTH : DW + 1;
    localparam int MA  = (MA0 > DT_WIDTH) ? MA0 : DT_WIDTH;
    localparam int MB0 = (DW > DT_WIDTH) ? DW : DT_WIDTH;
    localparam int MB  = (MB0 > NS_BITS) ? MB0 : NS_BITS;
    localparam int PW  = MA + MB;
    localparam int DV0 = DW + 1 + NS_BITS;
    localparam int DV  = (DV0 > DW + DT_WIDTH) ? DV0 : DW + DT_WIDTH;
    localparam int DD  = (DT_WIDTH > NS_BITS) ? DT_WIDTH : NS_BITS;
    localparam int TW  = PW - FRAC_BITS;
    localparam int SW  = TW + 3;
    localparam int IW2 = ((INTEG_WIDTH > DV) ? INTEG_WIDTH : DV) + 2;

    localparam logic [DV-1:0] Q_POS_MAX = {{(DV-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [DV-1:0] Q_NEG_MAX = Q_POS_MAX + DV'(1);
    localparam logic signed [IW2-1:0] IMAX =
        $signed({{(IW2-INTEG_WIDTH+1){1'b0}}, {(INTEG_WIDTH-1){1'b1}}});
    localparam logic signed [IW2-1:0] IMIN = -IMAX - IW2'(1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_M_RATE = 9'b000000010,
        S_D_RATE = 9'b000000100,
        S_M_INC  = 9'b000001000,
        S_D_INC  = 9'b000010000,
        S_M_I    = 9'b000100000,
        S_M_P    = 9'b001000000,
        S_M_D    = 9'b010000000,
        S_FIN    = 9'b100000000
    } pid_state_t;

    pid_state_t state_reg, state_next;

    logic signed [DW-1:0]          gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [DW-2:0]                 cmd_limit_reg;
    logic signed [DW-1:0]          last_err_reg;
    logic signed [INTEG_WIDTH-1:0] integ_reg;
    logic signed [DW-1:0]          err_reg;
    logic signed [DW-1:0]          rate_reg;
    logic [DT_WIDTH-1:0]           dt_reg;
    logic                          neg_reg;
    logic signed [SW-1:0]          acc_reg;
    logic                          computed_reg;
    logic                          out_vld_reg;
    logic signed [DW-1:0]          out_cmd_reg;
    logic                          out_cv_reg;

    logic                 in_xfer, out_load;
    logic signed [DW-1:0] src_err;
    logic [DW-1:0]        err_mag;
    logic signed [DW:0]   diff;
    logic [DW:0]          diff_mag;

    logic               mul_start, div_start;
    logic [MA-1:0]      mul_a;
    logic [MB-1:0]      mul_b;
    logic [PW-1:0]      mul_p;
    logic [DV-1:0]      div_n;
    logic [DD-1:0]      div_d;
    logic [DV-1:0]      div_q;
    pid_unit_st_t       mul_st, div_st;

    logic signed [DW-1:0]          rate_sat;
    logic signed [IW2-1:0]         inc_ext, integ_sum;
    logic signed [INTEG_WIDTH-1:0] integ_new;
    logic [INTEG_WIDTH-1:0]        integ_mag;
    logic signed [SW-1:0]          term, acc_sum, lim_s, cmd_sat;
    logic [DW-1:0]                 gi_mag, gp_mag, gd_mag, rate_mag;

    // serial arithmetic units
    pid_mul #(.A_W(MA), .B_W(MB)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_st),
        .product (mul_p)
    );

    pid_div #(.N_W(DV), .D_W(DD)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_n),
        .den      (div_d),
        .status   (div_st),
        .quotient (div_q)
    );

    assign sample.ready = (state_reg == S_IDLE);
    assign in_xfer      = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;
    assign out_load     = (state_reg == S_FIN) && (!out_vld_reg || result.ready);

    assign result.valid     = out_vld_reg;
    assign result.command   = out_cmd_reg;
    assign result.cmd_valid = out_cv_reg;

    // magnitudes of the operands
    always_comb
    begin
        src_err  = (state_reg == S_IDLE) ? sample.err_sample : err_reg;
        err_mag  = src_err[DW-1] ? DW'(-src_err) : DW'(src_err);
        diff     = {sample.err_sample[DW-1], sample.err_sample}
                 - {last_err_reg[DW-1], last_err_reg};
        diff_mag = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
        gi_mag   = gain_integ_reg[DW-1] ? DW'(-gain_integ_reg) : DW'(gain_integ_reg);
        gp_mag   = gain_prop_reg[DW-1] ? DW'(-gain_prop_reg) : DW'(gain_prop_reg);
        gd_mag   = gain_deriv_reg[DW-1] ? DW'(-gain_deriv_reg) : DW'(gain_deriv_reg);
        rate_mag = rate_reg[DW-1] ? DW'(-rate_reg) : DW'(rate_reg);
    end

    // derived rate, saturated to the data range
    always_comb
    begin
        if (neg_reg)
            rate_sat = (div_q > Q_NEG_MAX) ? $signed({1'b1, {(DW-1){1'b0}}})
                                           : -$signed(div_q[DW-1:0]);
        else
            rate_sat = (div_q > Q_POS_MAX) ? $signed({1'b0, {(DW-1){1'b1}}})
                                           : $signed(div_q[DW-1:0]);
    end

    // integral update with saturation
    always_comb
    begin
        inc_ext   = $signed(IW2'(div_q));
        integ_sum = IW2'(integ_reg) + (neg_reg ? -inc_ext : inc_ext);
        if (integ_sum > IMAX)
            integ_new = IMAX[INTEG_WIDTH-1:0];
        else if (integ_sum < IMIN)
            integ_new = IMIN[INTEG_WIDTH-1:0];
        else
            integ_new = integ_sum[INTEG_WIDTH-1:0];
        integ_mag = integ_new[INTEG_WIDTH-1] ? INTEG_WIDTH'(-integ_new)
                                             : INTEG_WIDTH'(integ_new);
    end

    // gain term, truncated toward zero, and command clamp
    always_comb
    begin
        term    = neg_reg ? -$signed(SW'(mul_p[PW-1:FRAC_BITS]))
                          : $signed(SW'(mul_p[PW-1:FRAC_BITS]));
        acc_sum = acc_reg + term;
        lim_s   = $signed(SW'(cmd_limit_reg));
        if (acc_reg > lim_s)
            cmd_sat = lim_s;
        else if (acc_reg < -lim_s)
            cmd_sat = -lim_s;
        else
            cmd_sat = acc_reg;
    end

    // sequencer and unit launches
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = MA'(err_mag);
        mul_b      = MB'(dt_reg);
        div_start  = 1'b0;
        div_n      = mul_p[DV-1:0];
        div_d      = DD'(dt_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (sample.operation == OP_CLEAR || sample.elapsed_ns == '0
                        || (sample.operation != OP_DERIVE
                            && sample.operation != OP_SUPPLIED))
                        state_next = S_FIN;
                    else if (sample.operation == OP_DERIVE)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = MA'(diff_mag);
                        mul_b      = NS_PER_SEC[MB-1:0];
                        state_next = S_M_RATE;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_b      = MB'(sample.elapsed_ns);
                        state_next = S_M_INC;
                    end
                end
            end
            S_M_RATE:
            begin
                if (mul_st.done)
                begin
                    div_start  = 1'b1;
                    state_next = S_D_RATE;
                end
            end
            S_D_RATE:
            begin
                if (div_st.done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_M_INC;
                end
            end
            S_M_INC:
            begin
                if (mul_st.done)
                begin
                    div_start  = 1'b1;
                    div_d      = NS_PER_SEC[DD-1:0];
                    state_next = S_D_INC;
                end
            end
            S_D_INC:
            begin
                if (div_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MA'(integ_mag);
                    mul_b      = MB'(gi_mag);
                    state_next = S_M_I;
                end
            end
            S_M_I:
            begin
                if (mul_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_b      = MB'(gp_mag);
                    state_next = S_M_P;
                end
            end
            S_M_P:
            begin
                if (mul_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MA'(rate_mag);
                    mul_b      = MB'(gd_mag);
                    state_next = S_M_D;
                end
            end
            S_M_D:
            begin
                if (mul_st.done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // step operands, sign of the running term and accumulator
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            err_reg  <= sample.err_sample;
            rate_reg <= sample.err_rate;
            dt_reg   <= sample.elapsed_ns;
            neg_reg  <= diff[DW];
            acc_reg  <= '0;
        end
        if (state_reg == S_D_RATE && div_st.done)
            rate_reg <= rate_sat;
        if (state_reg == S_M_INC && mul_st.done)
            neg_reg <= err_reg[DW-1];
        if (state_reg == S_D_INC && div_st.done)
            neg_reg <= integ_new[INTEG_WIDTH-1] ^ gain_integ_reg[DW-1];
        if (state_reg == S_M_I && mul_st.done)
        begin
            acc_reg <= acc_sum;
            neg_reg <= err_reg[DW-1] ^ gain_prop_reg[DW-1];
        end
        if (state_reg == S_M_P && mul_st.done)
        begin
            acc_reg <= acc_sum;
            neg_reg <= rate_reg[DW-1] ^ gain_deriv_reg[DW-1];
        end
        if (state_reg == S_M_D && mul_st.done)
            acc_reg <= acc_sum;
        if (out_load)
        begin
            out_cmd_reg <= cmd_sat[DW-1:0];
            out_cv_reg  <= computed_reg;
        end
    end

    // control state, controller state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_vld_reg    <= 1'b0;
            computed_reg   <= 1'b0;
            last_err_reg   <= '0;
            integ_reg      <= '0;
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            cmd_limit_reg  <= '1;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
            if (in_xfer)
            begin
                computed_reg <= 1'b0;
                if (sample.operation == OP_CLEAR)
                begin
                    last_err_reg <= '0;
                    integ_reg    <= '0;
                end
                else if (sample.operation == OP_DERIVE && sample.elapsed_ns != '0)
                    last_err_reg <= sample.err_sample;
            end
            if (state_reg == S_D_INC && div_st.done)
                integ_reg <= integ_new;
            if (state_reg == S_M_D && mul_st.done)
                computed_reg <= 1'b1;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_GAIN_PROP:  gain_prop_reg  <= $signed(cfg.data);
                    REG_GAIN_INTEG: gain_integ_reg <= $signed(cfg.data);
                    REG_GAIN_DERIV: gain_deriv_reg <= $signed(cfg.data);
                    REG_CMD_LIMIT:  cmd_limit_reg  <= cfg.data[DW-2:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[sv/pid_checker.sv]
// port-level checks of the pid controller and their binding
module pid_checker
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] command,
    input logic                  cmd_valid
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // no sample is taken in the cycle after a transfer
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while busy");

    // an invalid command is zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cmd_valid |-> command == '0)
        else $error("nonzero command without valid");

    // the symmetric clamp never reaches the most negative code
    a_clamp_sym: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_valid |-> command != {1'b1, {(DATA_WIDTH-1){1'b0}}})
        else $error("command outside symmetric limit");

endmodule

bind pid_controller pid_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .command   (result.command),
    .cmd_valid (result.cmd_valid)
);

[sim/tb_top.sv]
// self-checking testbench of the pid controller: directed and random control steps
`timescale 1ns / 100ps

module tb_top;
    import pid_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int IW = 48;
    localparam int TW = 32;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [DW-1:0] command;
        logic                 cmd_valid;
    } pid_cmd_t;

    logic clk;
    logic rst_n;

    pid_in_if  #(.DATA_WIDTH(DW), .DT_WIDTH(TW)) sample_ch ();
    pid_out_if #(.DATA_WIDTH(DW)) result_ch ();
    pid_cfg_if #(.DATA_WIDTH(DW)) cfg_ch ();

    pid_controller #(
        .DATA_WIDTH(DW), .FRAC_BITS(FB), .INTEG_WIDTH(IW), .DT_WIDTH(TW)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .sample(sample_ch.sink), .result(result_ch.source), .cfg(cfg_ch.sink)
    );

    // predictor copy of registers and state
    logic signed [DW-1:0] kp_q, ki_q, kd_q;
    logic [DW-2:0]        limit_q;
    logic signed [DW-1:0] last_err_q;
    logic signed [IW-1:0] integ_q;

    pid_cmd_t expected_cmds[$];
    int  fail_count;
    int  checked_count;
    int  step_count;
    longint cycle_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // saturate a wide signed value into a narrower signed range
    function automatic logic signed [127:0] clamp_wide(logic signed [127:0] v,
                                                        logic signed [127:0] lo,
                                                        logic signed [127:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // fixed point product truncated toward zero, saturated at 64 bits
    function automatic logic signed [127:0] fx_product(logic signed [127:0] a,
                                                        logic signed [127:0] b);
        logic signed [127:0] p;
        logic [127:0] m;
        p = a * b;
        m = p < 0 ? -p : p;
        m = m >> FB;
        if (m > 128'sh7FFFFFFFFFFFFFFF)
            m = 128'sh7FFFFFFFFFFFFFFF;
        return p < 0 ? -$signed(m) : $signed(m);
    endfunction

    // one control step of the predictor
    function automatic pid_cmd_t pid_predict(logic [1:0] op, logic signed [DW-1:0] err,
                                             logic signed [DW-1:0] rate_in,
                                             logic [TW-1:0] dt);
        pid_cmd_t r;
        logic signed [127:0] diff, rate, inc, cmd, lim, e, s64max;
        logic [127:0] m;
        r = '0;
        s64max = 128'sh7FFFFFFFFFFFFFFF;
        if (op == OP_CLEAR)
        begin
            last_err_q = '0;
            integ_q = '0;
            return r;
        end
        if (op == OP_UNUSED || dt == 0)
            return r;
        e = err;
        rate = rate_in;
        if (op == OP_DERIVE)
        begin
            diff = e - last_err_q;
            m = ((diff < 0) ? -diff : diff) * NS_PER_SEC / dt;
            if (m > s64max) m = s64max;
            rate = diff < 0 ? -$signed(m) : $signed(m);
            rate = clamp_wide(rate, -(128'sd1 <<< (DW-1)), (128'sd1 <<< (DW-1)) - 1);
            last_err_q = err;
        end
        m = ((e < 0) ? -e : e) * dt / NS_PER_SEC;
        inc = e < 0 ? -$signed(m) : $signed(m);
        integ_q = IW'(clamp_wide(integ_q + inc, -(128'sd1 <<< (IW-1)),
                                 (128'sd1 <<< (IW-1)) - 1));
        cmd = fx_product(ki_q, integ_q) + fx_product(kp_q, e);
        cmd = clamp_wide(cmd, -s64max - 1, s64max);
        cmd = clamp_wide(cmd + fx_product(kd_q, rate), -s64max - 1, s64max);
        lim = {97'd0, limit_q};
        cmd = clamp_wide(cmd, -lim, lim);
        r.command = cmd[DW-1:0];
        r.cmd_valid = 1'b1;
        return r;
    endfunction

    // result checker with random receiver stalls
    initial
    begin
        pid_cmd_t exp_cmd;
        int stall;
        result_ch.ready <= 1'b0;
        fail_count = 0;
        checked_count = 0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            if (expected_cmds.size() == 0)
            begin
                $error("result transfer with no command expected");
                fail_count++;
            end
            else
            begin
                exp_cmd = expected_cmds.pop_front();
                checked_count++;
                if (result_ch.command !== exp_cmd.command)
                begin
                    $error("command expected %0d actual %0d", exp_cmd.command,
                           result_ch.command);
                    fail_count++;
                end
                if (result_ch.cmd_valid !== exp_cmd.cmd_valid)
                begin
                    $error("cmd_valid expected %0d actual %0d", exp_cmd.cmd_valid,
                           result_ch.cmd_valid);
                    fail_count++;
                end
            end
        end
    end

    // send one sample transfer after a random gap; valid drops in the gap
    task automatic send_sample(logic [1:0] op, logic [DW-1:0] err, logic [DW-1:0] rate,
                               logic [TW-1:0] dt);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.operation  <= op;
        sample_ch.err_sample <= err;
        sample_ch.err_rate   <= rate;
        sample_ch.elapsed_ns <= dt;
        do @(posedge clk); while (!sample_ch.ready);
        expected_cmds.push_back(pid_predict(op, err, rate, dt));
        step_count++;
    endtask

    // wait until all results are in, then let the block settle
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // register write while idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_GAIN_PROP:  kp_q = val;
            REG_GAIN_INTEG: ki_q = val;
            REG_GAIN_DERIV: kd_q = val;
            REG_CMD_LIMIT:  limit_q = val[DW-2:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [DW-1:0] kp, logic [DW-1:0] ki, logic [DW-1:0] kd,
                             logic [DW-1:0] lim);
        drain_results();
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_CMD_LIMIT, lim);
        cfg_ch.valid <= 1'b0;
    endtask

    // random error value biased to small and extreme magnitudes
    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            1: return $urandom;
            default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_dt();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            2: return 32'hFFFFFFFF;
            default: return $urandom_range(1, 20000000);
        endcase
    endfunction

    // directed extremes and special cases
    task automatic test_directed();
        send_sample(OP_DERIVE, 32'h00010000, 32'h0, 32'd1000000);
        set_gains(32'h00010000, 32'h00008000, 32'h00000100, 32'h7FFFFFFF);
        send_sample(OP_DERIVE, 32'h00010000, 32'h0, 32'd1000000);
        send_sample(OP_DERIVE, 32'h00020000, 32'h0, 32'd1);
        send_sample(OP_DERIVE, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF);
        send_sample(OP_DERIVE, 32'h80000000, 32'h0, 32'd1);
        send_sample(OP_SUPPLIED, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_sample(OP_SUPPLIED, 32'h80000000, 32'h80000000, 32'hFFFFFFFF);
        send_sample(OP_DERIVE, 32'h00030000, 32'h0, 32'd0);
        send_sample(OP_SUPPLIED, 32'h00030000, 32'h1, 32'd0);
        send_sample(OP_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd5);
        send_sample(OP_CLEAR, 32'h0, 32'h0, 32'd0);
        send_sample(OP_UNUSED, 32'h12345678, 32'h0, 32'd100);
        send_sample(OP_DERIVE, 32'h0, 32'h0, 32'd1000);
        set_gains(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
        send_sample(OP_DERIVE, 32'h7FFFFFFF, 32'h0, 32'd3);
        send_sample(OP_SUPPLIED, 32'h80000000, 32'h80000000, 32'd7);
        set_gains(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_sample(OP_DERIVE, 32'h80000000, 32'h0, 32'd2);
        send_sample(OP_SUPPLIED, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_sample(OP_SUPPLIED, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    endtask

    // random control runs across several register settings
    task automatic test_random();
        logic [1:0] op;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_gains(32'h00010000, 32'h00000800, 32'h00000010, 32'h00500000);
                1: set_gains($urandom, $urandom, $urandom, $urandom);
                2: set_gains(32'hFFFF0000, 32'h00020000, 32'hFFFFFF00, 32'h7FFFFFFF);
                3: set_gains(32'h0, 32'h0, 32'h0, 32'h1);
                default: set_gains($urandom, $urandom, $urandom, 32'h7FFFFFFF);
            endcase
            for (int i = 0; i < 126; i++)
            begin
                case ($urandom_range(0, 19))
                    0: op = OP_CLEAR;
                    1: op = OP_UNUSED;
                    default: op = $urandom_range(0, 1) ? OP_DERIVE : OP_SUPPLIED;
                endcase
                send_sample(op, pick_value(), pick_value(), pick_dt());
            end
        end
    endtask

    // sender holds off until the block has emptied
    task automatic test_hold_off();
        for (int i = 0; i < 10; i++)
        begin
            send_sample(OP_SUPPLIED, pick_value(), pick_value(), pick_dt());
            sample_ch.valid <= 1'b0;
            while (expected_cmds.size() != 0) @(posedge clk);
        end
    endtask

    // sequence of tests
    initial
    begin
        rst_n = 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.operation <= OP_DERIVE;
        sample_ch.err_sample <= '0;
        sample_ch.err_rate <= '0;
        sample_ch.elapsed_ns <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_GAIN_PROP;
        cfg_ch.data <= '0;
        kp_q = '0; ki_q = '0; kd_q = '0;
        limit_q = '1;
        last_err_q = '0;
        integ_q = '0;
        step_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_hold_off();
        drain_results();
        $display("covered %0d control steps, %0d results checked, reset gains plus eight settings",
                 step_count, checked_count);
        $display("derive, supplied, clear, unused code, zero time and saturation hit");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
